// File: rtl/psum_pkg.sv
// Shared types and constants for the prime sum core.
`default_nettype none

package psum_pkg;

	// Largest limit that the sieve covers and the widths that follow from it.
	localparam int LIMIT_MAX = 65535;
	localparam int LIMIT_W   = 16;
	localparam int CNT_W     = LIMIT_W + 1;
	localparam int ROOT_W    = 9;
	localparam int SQ_W      = 2 * ROOT_W;
	localparam int SUM_W     = 32;
	localparam int DEPTH     = LIMIT_MAX + 1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SQ,
		ST_TEST,
		ST_MARK,
		ST_SUM,
		ST_SUM_END,
		ST_DONE
	} state_t;

	// Control bundle from the sequencer to the sieve bitmap.
	typedef struct packed {
		logic               we;
		logic [LIMIT_W-1:0] waddr;
		logic               wdata;
		logic [LIMIT_W-1:0] raddr;
	} mem_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/prime_sum_up_to_limit_core.sv
// Top level of the prime sum core: sieve sequencer, accumulator and stream ports.
//
// Channel   Direction  Signals                                Contents
// s_axis    in         s_axis_tvalid/tready/tdata[15:0]       limit
// m_axis    out        m_axis_tvalid/tready/tdata[31:0]       prime_sum
//
// One transaction of limit n clears the bitmap, then tests each candidate root in turn
// while its square is at most n, marks the multiples of each unmarked root from its
// square upward, and then sums the unmarked integers from two to n. Limits below two
// present their result in the cycle after acceptance.
// The input is not ready while an item is at work or its result waits on m_axis.
// Reset clears the sequencer only; the bitmap is cleared per item before use.
`default_nettype none

module prime_sum_up_to_limit_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] limit
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // [31:0] prime_sum
);

	psum_pkg::state_t                  state_q, state_d;
	logic [psum_pkg::LIMIT_W-1:0]      n_q;
	logic [psum_pkg::CNT_W-1:0]        i_q;
	logic [psum_pkg::CNT_W-1:0]        j_q;
	logic [psum_pkg::CNT_W-1:0]        j_next;
	logic [psum_pkg::SQ_W-1:0]         sq_q;
	logic [psum_pkg::SQ_W-1:0]         sq_prod;
	logic [psum_pkg::CNT_W-1:0]        pidx_q;
	logic                              pend_q;
	logic [psum_pkg::SUM_W-1:0]        acc_q;
	logic                              rd_bit;
	logic                              in_fire;
	logic                              out_fire;
	logic                              last_i;
	psum_pkg::mem_ctrl_t               mem_ctrl;

	assign in_fire  = s_axis_tvalid & s_axis_tready;
	assign out_fire = m_axis_tvalid & m_axis_tready;
	assign j_next   = j_q + i_q;
	assign sq_prod  = i_q[psum_pkg::ROOT_W-1:0] * i_q[psum_pkg::ROOT_W-1:0];
	assign last_i   = (i_q == {1'b0, n_q});

	psum_bitmap u_bitmap (
		.clk    (clk),
		.ctrl   (mem_ctrl),
		.rd_bit (rd_bit)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			psum_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = (s_axis_tdata < 16'd2) ? psum_pkg::ST_DONE : psum_pkg::ST_CLEAR;
				end
			end
			psum_pkg::ST_CLEAR: begin
				if (last_i) begin
					state_d = psum_pkg::ST_SQ;
				end
			end
			psum_pkg::ST_SQ: begin
				state_d = psum_pkg::ST_TEST;
			end
			psum_pkg::ST_TEST: begin
				if (sq_q > {{(psum_pkg::SQ_W-psum_pkg::LIMIT_W){1'b0}}, n_q}) begin
					state_d = psum_pkg::ST_SUM;
				end else if (rd_bit) begin
					state_d = psum_pkg::ST_SQ;
				end else begin
					state_d = psum_pkg::ST_MARK;
				end
			end
			psum_pkg::ST_MARK: begin
				if (j_next > {1'b0, n_q}) begin
					state_d = psum_pkg::ST_SQ;
				end
			end
			psum_pkg::ST_SUM: begin
				if (last_i) begin
					state_d = psum_pkg::ST_SUM_END;
				end
			end
			psum_pkg::ST_SUM_END: begin
				state_d = psum_pkg::ST_DONE;
			end
			psum_pkg::ST_DONE: begin
				if (out_fire) begin
					state_d = psum_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = psum_pkg::ST_IDLE;
			end
		endcase
	end

	// Handshake outputs and bitmap control.
	always_comb begin
		s_axis_tready  = (state_q == psum_pkg::ST_IDLE);
		m_axis_tvalid  = (state_q == psum_pkg::ST_DONE);
		mem_ctrl.we    = 1'b0;
		mem_ctrl.waddr = i_q[psum_pkg::LIMIT_W-1:0];
		mem_ctrl.wdata = 1'b0;
		mem_ctrl.raddr = i_q[psum_pkg::LIMIT_W-1:0];
		case (state_q)
			psum_pkg::ST_CLEAR: begin
				mem_ctrl.we = 1'b1;
			end
			psum_pkg::ST_MARK: begin
				mem_ctrl.we    = 1'b1;
				mem_ctrl.waddr = j_q[psum_pkg::LIMIT_W-1:0];
				mem_ctrl.wdata = 1'b1;
			end
			default: begin
				mem_ctrl.we = 1'b0;
			end
		endcase
	end

	assign m_axis_tdata = acc_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psum_pkg::ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == psum_pkg::ST_SUM) begin
				pend_q <= 1'b1;
			end else begin
				pend_q <= 1'b0;
			end
		end
	end

	// Datapath: loop counters, square of the root and the accumulator.
	always_ff @(posedge clk) begin
		case (state_q)
			psum_pkg::ST_IDLE: begin
				n_q   <= s_axis_tdata;
				i_q   <= '0;
				acc_q <= '0;
			end
			psum_pkg::ST_CLEAR: begin
				i_q <= last_i ? psum_pkg::CNT_W'(2) : i_q + 1'b1;
			end
			psum_pkg::ST_SQ: begin
				sq_q <= sq_prod;
			end
			psum_pkg::ST_TEST: begin
				if (sq_q > {{(psum_pkg::SQ_W-psum_pkg::LIMIT_W){1'b0}}, n_q}) begin
					i_q <= psum_pkg::CNT_W'(2);
				end else if (rd_bit) begin
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= sq_q[psum_pkg::CNT_W-1:0];
				end
			end
			psum_pkg::ST_MARK: begin
				j_q <= j_next;
				if (j_next > {1'b0, n_q}) begin
					i_q <= i_q + 1'b1;
				end
			end
			psum_pkg::ST_SUM: begin
				pidx_q <= i_q;
				i_q    <= i_q + 1'b1;
				if (pend_q && !rd_bit) begin
					acc_q <= acc_q + {{(psum_pkg::SUM_W-psum_pkg::CNT_W){1'b0}}, pidx_q};
				end
			end
			psum_pkg::ST_SUM_END: begin
				if (pend_q && !rd_bit) begin
					acc_q <= acc_q + {{(psum_pkg::SUM_W-psum_pkg::CNT_W){1'b0}}, pidx_q};
				end
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/psum_bitmap.sv
// Sieve bitmap: one bit per integer, one write port, one registered read port.
`default_nettype none

module psum_bitmap (
	input  wire logic                clk,
	input  wire psum_pkg::mem_ctrl_t ctrl,
	output logic                     rd_bit
);

	// Bit k set means k is known to be composite.
	logic mem [0:psum_pkg::DEPTH-1];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem[ctrl.waddr] <= ctrl.wdata;
		end
		rd_bit <= mem[ctrl.raddr];
	end

endmodule

`default_nettype wire
